@@ src/mtrs_pkg.sv @@
// ----------------------------------------------------------------------------
// mtrs_pkg
// Shared types and constants of the Modbus TCP register server.
// ----------------------------------------------------------------------------
package mtrs_pkg;

    typedef logic [7:0]  byte_t;
    typedef logic [15:0] word_t;

    localparam int POS_W = 10;
    localparam logic [POS_W-1:0] POS_SAT = 10'd1023;

    localparam int HDR_LEN    = 12;
    localparam int DATA_START = 13;
    localparam int HDR_UNIT   = 6;
    localparam int HDR_FN     = 7;
    localparam int HDR_START  = 8;
    localparam int HDR_QTY    = 10;

    localparam int RSP_LEN_HI   = 4;
    localparam int RSP_LEN_LO   = 5;
    localparam int RSP_UNIT     = 6;
    localparam int RSP_FN       = 7;
    localparam int RSP_BYTE_CNT = 8;

    localparam byte_t FN_READ_COILS   = 8'h01;
    localparam byte_t FN_READ_HOLDING = 8'h03;
    localparam byte_t FN_WRITE_COILS  = 8'h0F;
    localparam byte_t FN_WRITE_MULTI  = 8'h10;
    localparam byte_t WRITE_ECHO_LEN  = 8'h06;
    localparam byte_t UNIT_ALWAYS     = 8'h01;
    localparam byte_t LEN_TAIL        = 8'h03;

    localparam int COIL_SHIFT = 4;

endpackage

@@ src/modbus_tcp_register_server.sv @@
// ----------------------------------------------------------------------------
// modbus_tcp_register_server
// Request bytes: one per cycle while busy is low; writes land in the register
// memory as data bytes stream in. After the last byte: a decode state; if
// served, one response byte per cycle (9 + 2n for n registers read, 12 for a
// write), then ready again. Reset: busy for REG_COUNT cycles while the
// register memory is cleared one entry per cycle; unit register resets to 1.
// ----------------------------------------------------------------------------
module modbus_tcp_register_server #(
    parameter int REG_COUNT     = 256,
    parameter int MAX_READ_REGS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mtrs_pkg::byte_t     rx_byte,
    input  logic                frame_end,
    input  logic                cfg_we,
    input  mtrs_pkg::byte_t     cfg_wdata,
    output logic                tx_valid,
    output mtrs_pkg::byte_t     tx_byte,
    output logic                last
);

    localparam int AW    = $clog2(REG_COUNT);
    localparam int CNT_W = $clog2(MAX_READ_REGS + 1);
    localparam int IDX_W = $clog2(2 * MAX_READ_REGS + 9);
    localparam int PW    = mtrs_pkg::POS_W;

    typedef enum logic [3:0] {
        ST_CLEAR  = 4'b0001,
        ST_IDLE   = 4'b0010,
        ST_DECIDE = 4'b0100,
        ST_EMIT   = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [PW-1:0]        pos_reg, pos_next;
    mtrs_pkg::byte_t      pending_reg, pending_next;
    mtrs_pkg::byte_t      unit_reg;
    logic [AW-1:0]        clr_reg, clr_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 frame_ok_reg, frame_ok_next;
    logic                 is_read_reg, is_read_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [IDX_W-1:0]     last_idx_reg, last_idx_next;
    logic [AW-1:0]        addr_reg, addr_next;

    mtrs_pkg::byte_t      hdr_reg [mtrs_pkg::HDR_LEN];
    logic [15:0]          mem [REG_COUNT];
    mtrs_pkg::word_t      rd_data_reg;

    logic                 accept;
    logic                 served;
    mtrs_pkg::byte_t      fn;
    mtrs_pkg::word_t      start_word;
    mtrs_pkg::word_t      qty;
    logic [AW-1:0]        base;
    logic [AW-1:0]        addr_inc;
    logic [PW-1:0]        off;
    logic [PW-2:0]        slot;
    logic                 wr_zone;
    logic                 mem_we;
    logic                 mem_re;
    logic [AW-1:0]        mem_waddr;
    mtrs_pkg::word_t      mem_wdata;
    mtrs_pkg::word_t      cnt_sel;
    logic [CNT_W-1:0]     cnt_clamp;
    mtrs_pkg::byte_t      hdr_at;
    mtrs_pkg::byte_t      cnt2;

    mtrs_addr_mod #(
        .REG_COUNT (REG_COUNT)
    ) u_addr_mod (
        .clk        (clk),
        .start_addr (start_word),
        .base       (base)
    );

    assign accept     = start && !busy;
    assign busy       = (state_reg != ST_IDLE);
    assign fn         = hdr_reg[mtrs_pkg::HDR_FN];
    assign start_word = {hdr_reg[mtrs_pkg::HDR_START], hdr_reg[mtrs_pkg::HDR_START + 1]};
    assign qty        = {hdr_reg[mtrs_pkg::HDR_QTY], hdr_reg[mtrs_pkg::HDR_QTY + 1]};
    assign served     = (hdr_reg[mtrs_pkg::HDR_UNIT] == unit_reg)
                     || (hdr_reg[mtrs_pkg::HDR_UNIT] == mtrs_pkg::UNIT_ALWAYS);
    assign addr_inc   = (addr_reg == AW'(REG_COUNT - 1)) ? '0 : addr_reg + AW'(1);
    assign off        = pos_reg - PW'(mtrs_pkg::DATA_START);
    assign slot       = off[PW-1:1];
    assign wr_zone    = (pos_reg >= PW'(mtrs_pkg::DATA_START)) && (pos_reg < mtrs_pkg::POS_SAT)
                     && served && (16'(slot) < qty);

    always_comb
    begin
        cnt_sel = (fn == mtrs_pkg::FN_READ_HOLDING) ? qty : (qty >> mtrs_pkg::COIL_SHIFT);
        if (cnt_sel > 16'(MAX_READ_REGS))
        begin
            cnt_clamp = CNT_W'(MAX_READ_REGS);
        end
        else
        begin
            cnt_clamp = cnt_sel[CNT_W-1:0];
        end
    end

    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = addr_reg;
        mem_wdata = {pending_reg, rx_byte};
        if (state_reg == ST_CLEAR)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_reg;
            mem_wdata = '0;
        end
        else if (accept && wr_zone)
        begin
            priority if (fn == mtrs_pkg::FN_WRITE_MULTI)
            begin
                mem_we = !pos_reg[0];
            end
            else if (fn == mtrs_pkg::FN_WRITE_COILS)
            begin
                mem_we    = pos_reg[0];
                mem_wdata = {rx_byte, 8'h00};
            end
            else
            begin
                mem_we = 1'b0;
            end
        end
    end

    assign mem_re = (state_reg == ST_EMIT) && is_read_reg
                 && (idx_reg >= IDX_W'(mtrs_pkg::RSP_BYTE_CNT)) && !idx_reg[0];

    always_comb
    begin
        state_next    = state_reg;
        pos_next      = pos_reg;
        pending_next  = pending_reg;
        clr_next      = clr_reg;
        idx_next      = idx_reg;
        frame_ok_next = frame_ok_reg;
        is_read_next  = is_read_reg;
        cnt_next      = cnt_reg;
        last_idx_next = last_idx_reg;
        addr_next     = addr_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(REG_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (pos_reg < mtrs_pkg::POS_SAT)
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                    if (wr_zone && (fn == mtrs_pkg::FN_WRITE_MULTI) && pos_reg[0])
                    begin
                        pending_next = rx_byte;
                    end
                    if (pos_reg == PW'(mtrs_pkg::HDR_LEN))
                    begin
                        addr_next = base;
                    end
                    else if ((pos_reg > PW'(mtrs_pkg::DATA_START)) && !pos_reg[0])
                    begin
                        addr_next = addr_inc;
                    end
                    if (frame_end)
                    begin
                        pos_next      = '0;
                        pending_next  = '0;
                        frame_ok_next = (pos_reg >= PW'(mtrs_pkg::HDR_LEN - 1));
                        state_next    = ST_DECIDE;
                    end
                end
            end
            ST_DECIDE:
            begin
                idx_next   = '0;
                addr_next  = base;
                state_next = ST_IDLE;
                if (frame_ok_reg && served)
                begin
                    priority if ((fn == mtrs_pkg::FN_READ_HOLDING)
                              || (fn == mtrs_pkg::FN_READ_COILS))
                    begin
                        is_read_next  = 1'b1;
                        cnt_next      = cnt_clamp;
                        last_idx_next = IDX_W'(mtrs_pkg::RSP_BYTE_CNT)
                                      + IDX_W'({cnt_clamp, 1'b0});
                        state_next    = ST_EMIT;
                    end
                    else if ((fn == mtrs_pkg::FN_WRITE_MULTI)
                          || (fn == mtrs_pkg::FN_WRITE_COILS))
                    begin
                        is_read_next  = 1'b0;
                        last_idx_next = IDX_W'(mtrs_pkg::HDR_LEN - 1);
                        state_next    = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT:
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (mem_re)
                begin
                    addr_next = addr_inc;
                end
                if (idx_reg == last_idx_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            pos_reg      <= '0;
            pending_reg  <= '0;
            unit_reg     <= mtrs_pkg::UNIT_ALWAYS;
            clr_reg      <= '0;
            idx_reg      <= '0;
            frame_ok_reg <= 1'b0;
            is_read_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            pos_reg      <= pos_next;
            pending_reg  <= pending_next;
            clr_reg      <= clr_next;
            idx_reg      <= idx_next;
            frame_ok_reg <= frame_ok_next;
            is_read_reg  <= is_read_next;
            if (cfg_we)
            begin
                unit_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg      <= cnt_next;
        last_idx_reg <= last_idx_next;
        addr_reg     <= addr_next;
        if (accept && (pos_reg < PW'(mtrs_pkg::HDR_LEN)))
        begin
            hdr_reg[pos_reg[3:0]] <= rx_byte;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rd_data_reg <= mem[addr_reg];
        end
    end

    assign cnt2 = 8'({cnt_reg, 1'b0});

    always_comb
    begin
        hdr_at = '0;
        if (idx_reg < IDX_W'(mtrs_pkg::HDR_LEN))
        begin
            hdr_at = hdr_reg[idx_reg[3:0]];
        end
        tx_byte = hdr_at;
        if (is_read_reg)
        begin
            priority if (idx_reg == IDX_W'(mtrs_pkg::RSP_LEN_HI))
            begin
                tx_byte = '0;
            end
            else if (idx_reg == IDX_W'(mtrs_pkg::RSP_LEN_LO))
            begin
                tx_byte = cnt2 + mtrs_pkg::LEN_TAIL;
            end
            else if (idx_reg == IDX_W'(mtrs_pkg::RSP_BYTE_CNT))
            begin
                tx_byte = cnt2;
            end
            else if (idx_reg > IDX_W'(mtrs_pkg::RSP_BYTE_CNT))
            begin
                tx_byte = idx_reg[0] ? rd_data_reg[15:8] : rd_data_reg[7:0];
            end
            else
            begin
                tx_byte = hdr_at;
            end
        end
        else
        begin
            priority if (idx_reg == IDX_W'(mtrs_pkg::RSP_LEN_HI))
            begin
                tx_byte = '0;
            end
            else if (idx_reg == IDX_W'(mtrs_pkg::RSP_LEN_LO))
            begin
                tx_byte = mtrs_pkg::WRITE_ECHO_LEN;
            end
            else
            begin
                tx_byte = hdr_at;
            end
        end
    end

    assign tx_valid = (state_reg == ST_EMIT);
    assign last     = tx_valid && (idx_reg == last_idx_reg);

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid && last) |=> !tx_valid)
        else $error("response continued after its final byte");

    a_emit_after_decide: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(tx_valid) |-> $past(state_reg == ST_DECIDE))
        else $error("response started without a decode cycle");

    a_no_write_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (state_reg != ST_EMIT))
        else $error("register write during response");

    a_clear_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> (busy && !tx_valid))
        else $error("ready or response during memory clear");

endmodule

@@ src/mtrs_addr_mod.sv @@
// ----------------------------------------------------------------------------
// mtrs_addr_mod
// Start address modulo the register count, by reciprocal multiply in two
// registered steps.
// ----------------------------------------------------------------------------
module mtrs_addr_mod #(
    parameter int REG_COUNT = 256
) (
    input  logic                         clk,
    input  mtrs_pkg::word_t              start_addr,
    output logic [$clog2(REG_COUNT)-1:0] base
);

    localparam int AW = $clog2(REG_COUNT);
    localparam int SH = 16 + AW;
    localparam int RW = 18;
    localparam int PW = 16 + RW;
    localparam int unsigned RECIP = ((32'd1 << SH) + REG_COUNT - 1) / REG_COUNT;

    logic [PW-1:0]   prod;
    mtrs_pkg::word_t quot_reg;
    mtrs_pkg::word_t addr_d_reg;
    mtrs_pkg::word_t rem;
    mtrs_pkg::word_t rem_fix;
    logic [AW-1:0]   base_reg;

    assign prod = PW'(start_addr) * PW'(RECIP);

    always_ff @(posedge clk)
    begin
        quot_reg   <= 16'(prod >> SH);
        addr_d_reg <= start_addr;
    end

    always_comb
    begin
        rem     = addr_d_reg - 16'(32'(quot_reg) * 32'(REG_COUNT));
        rem_fix = rem;
        if (rem >= 16'(REG_COUNT))
        begin
            rem_fix = rem - 16'(REG_COUNT);
        end
    end

    always_ff @(posedge clk)
    begin
        base_reg <= AW'(rem_fix);
    end

    assign base = base_reg;

endmodule
